### design/wreta_pkg.sv
// Shared types and constants of the windowed rate and ETA estimator.
// Holds the request/result structs, status and function codes, and the
// controller-to-datapath command and status bundles. No dependencies.
package wreta_pkg;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned RATE_W    = 58;
  localparam int unsigned ETA_W     = 17;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_W    = 16;
  // Product of a 32-bit value step and 1000 fits in 42 bits.
  localparam int unsigned PROD_W    = VAL_W + 10;

  localparam logic [TIME_W-1:0] AGE_LIMIT_MS   = 48'd120000;
  localparam logic [TIME_W-1:0] MIN_WINDOW_RST = 48'd30000;
  localparam int unsigned       STABLE_MIN_CNT = 10;
  localparam int unsigned       ETA_LIMIT      = 24 * 3600;
  localparam int unsigned       MS_PER_S       = 1000;
  localparam logic [RATE_W-1:0] RATE_MAX       = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ESTIMATE   = 3'd0,
    ST_FROZEN     = 3'd1,
    ST_NOT_STABLE = 3'd2,
    ST_STALLED    = 3'd3,
    ST_TOO_FAR    = 3'd4,
    ST_DONE       = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WINDOW = 2'd0,
    CFG_FROZEN     = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] time_ms;
    logic [VAL_W-1:0]  progress;
    logic [VAL_W-1:0]  goal;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ETA_W-1:0]     eta_secs;
    logic [RATE_W-1:0]    rate_q16;
    logic [CNT_OUT_W-1:0] sample_count;
  } out_item_t;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LATCH,
    OP_CLEAR,
    OP_MAKE_ROOM,
    OP_WRITE,
    OP_RD_FIRST,
    OP_RD_LAST,
    OP_RD_NEXT,
    OP_DROP,
    OP_CAP_FIRST,
    OP_CAP_LAST,
    OP_CAP_PAIR,
    OP_MUL_BASE,
    OP_MUL_PAIR,
    OP_DIV_BASE,
    OP_DIV_PAIR,
    OP_DIV_AVG,
    OP_DIV_ETA,
    OP_ACC_PAIR,
    OP_TAKE_RATE,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e status;
    logic    with_eta;
    logic    with_rate;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  frozen;
    logic  prog_ge_goal;
    logic  held_lt2;
    logic  not_stable;
    logic  base_zero;
    logic  age_stale;
    logic  pair_ok;
    logic  more_pairs;
    logic  cnt_zero;
    logic  rate_zero;
    logic  div_busy;
    logic  eta_over;
    logic  out_free;
  } sts_t;

endpackage

### design/wreta_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by wreta_dp for every division of the block.
module wreta_div #(
  parameter int unsigned NW = 63,
  parameter int unsigned DW = 58
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            fits;

  // Shift in the next numerator bit and try one subtraction.
  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  // Control state of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Quotient and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], fits};
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### design/wreta_dp.sv
// Datapath: sample rings, window pointers, configuration registers,
// rate arithmetic and the result register. Uses wreta_pkg and wreta_div.
module wreta_dp #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wreta_pkg::cmd_t                cmd_i,
  output wreta_pkg::sts_t                sts_o,
  input  wreta_pkg::in_item_t            in_item_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wreta_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wreta_pkg::TIME_W-1:0]   cfg_data_i,
  output logic                           out_valid_o,
  output wreta_pkg::out_item_t           out_item_o,
  input  logic                           out_stall_i
);
  import wreta_pkg::*;

  localparam int unsigned AW   = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW   = CW + 1;
  localparam int unsigned NW   = RATE_W + AW;
  localparam int unsigned DW   = RATE_W;
  localparam int unsigned PADW = NW - RATE_W;

  // Configuration and window pointers.
  logic [TIME_W-1:0] min_q;
  logic              frozen_q;
  logic [AW-1:0]     oldest_q;
  logic [CW-1:0]     held_q;

  // Sample memories.
  logic [TIME_W-1:0] stamp_mem [WINDOW_DEPTH];
  logic [VAL_W-1:0]  value_mem [WINDOW_DEPTH];
  logic [TIME_W-1:0] rd_stamp_q;
  logic [VAL_W-1:0]  rd_val_q;

  // Query working registers.
  in_item_t          item_q;
  logic [CW-1:0]     off_q;
  logic [TIME_W-1:0] first_stamp_q;
  logic [VAL_W-1:0]  first_val_q;
  logic [VAL_W-1:0]  last_val_q;
  logic [TIME_W-1:0] span_q;
  logic [TIME_W-1:0] prev_stamp_q;
  logic [VAL_W-1:0]  prev_val_q;
  logic [TIME_W-1:0] dt_q;
  logic [VAL_W-1:0]  dv_q;
  logic              pair_ok_q;
  logic [PROD_W-1:0] prod_q;
  logic [NW-1:0]     sum_q;
  logic [CW-1:0]     cnt_q;
  logic [RATE_W-1:0] rate_q;

  // Result register.
  logic              out_valid_q;
  out_item_t         out_q;

  logic [CW-1:0]     off;
  logic [SW-1:0]     addr_sum;
  logic [SW-1:0]     addr_wrap;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     oldest_inc;
  logic              rd_en;
  logic [31:0]       held32;
  logic [VAL_W-1:0]  mul_a;
  logic [TIME_W-1:0] age;
  logic              div_start;
  logic [NW-1:0]     div_num;
  logic [DW-1:0]     div_den;
  logic              div_busy;
  logic [NW-1:0]     div_quo;
  logic [DW-1:0]     div_rem;
  logic [VAL_W-1:0]  remaining;
  logic [CW+5:0]     held_ext;

  // Slot offset from the oldest entry for the current access.
  always_comb begin
    unique case (cmd_i.op)
      OP_RD_LAST: off = held_q - 1'b1;
      OP_RD_NEXT: off = off_q;
      OP_WRITE:   off = held_q;
      default:    off = '0;
    endcase
  end

  // Ring address, wrapped into the depth.
  assign addr_sum  = SW'(oldest_q) + SW'(off);
  assign addr_wrap = (addr_sum >= SW'(WINDOW_DEPTH)) ? addr_sum - SW'(WINDOW_DEPTH) : addr_sum;
  assign addr      = addr_wrap[AW-1:0];
  assign oldest_inc = (oldest_q == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
  assign rd_en = (cmd_i.op == OP_RD_FIRST) || (cmd_i.op == OP_RD_LAST) ||
                 (cmd_i.op == OP_RD_NEXT);

  // Sample memories: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) begin
      stamp_mem[addr] <= item_q.time_ms;
      value_mem[addr] <= item_q.progress;
    end
    if (rd_en) begin
      rd_stamp_q <= stamp_mem[addr];
      rd_val_q   <= value_mem[addr];
    end
  end

  // Configuration writes and window pointer updates.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= MIN_WINDOW_RST;
      frozen_q <= 1'b0;
      oldest_q <= '0;
      held_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MIN_WINDOW) begin
          min_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_FROZEN) begin
          frozen_q <= cfg_data_i[0];
        end
      end
      unique case (cmd_i.op)
        OP_CLEAR: begin
          oldest_q <= '0;
          held_q   <= '0;
        end
        OP_MAKE_ROOM: begin
          if (held_q >= CW'(WINDOW_DEPTH)) begin
            oldest_q <= oldest_inc;
            held_q   <= CW'(WINDOW_DEPTH - 1);
          end
        end
        OP_WRITE: held_q <= held_q + 1'b1;
        OP_DROP: begin
          oldest_q <= oldest_inc;
          held_q   <= held_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Divider operand selection.
  assign remaining = item_q.goal - item_q.progress;
  assign div_start = (cmd_i.op == OP_DIV_BASE) || (cmd_i.op == OP_DIV_PAIR) ||
                     (cmd_i.op == OP_DIV_AVG) || (cmd_i.op == OP_DIV_ETA);

  always_comb begin
    unique case (cmd_i.op)
      OP_DIV_AVG: begin
        div_num = sum_q;
        div_den = {{(DW-CW){1'b0}}, cnt_q};
      end
      OP_DIV_ETA: begin
        div_num = {{(NW-VAL_W-FRAC_W){1'b0}}, remaining, {FRAC_W{1'b0}}};
        div_den = rate_q;
      end
      OP_DIV_PAIR: begin
        div_num = {{PADW{1'b0}}, prod_q, {FRAC_W{1'b0}}};
        div_den = {{(DW-TIME_W){1'b0}}, dt_q};
      end
      default: begin
        div_num = {{PADW{1'b0}}, prod_q, {FRAC_W{1'b0}}};
        div_den = {{(DW-TIME_W){1'b0}}, span_q};
      end
    endcase
  end

  wreta_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // Multiplier operand: whole-window step or one pair step.
  assign mul_a = (cmd_i.op == OP_MUL_BASE) ? last_val_q - first_val_q : dv_q;

  // Query working registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: item_q <= in_item_i;
      OP_CAP_FIRST: begin
        first_stamp_q <= rd_stamp_q;
        first_val_q   <= rd_val_q;
        prev_stamp_q  <= rd_stamp_q;
        prev_val_q    <= rd_val_q;
        off_q         <= CW'(1);
        sum_q         <= '0;
        cnt_q         <= '0;
      end
      OP_CAP_LAST: begin
        span_q     <= rd_stamp_q - first_stamp_q;
        last_val_q <= rd_val_q;
      end
      OP_CAP_PAIR: begin
        dt_q         <= rd_stamp_q - prev_stamp_q;
        dv_q         <= rd_val_q - prev_val_q;
        pair_ok_q    <= (rd_stamp_q != prev_stamp_q) && (rd_val_q >= prev_val_q);
        prev_stamp_q <= rd_stamp_q;
        prev_val_q   <= rd_val_q;
        off_q        <= off_q + 1'b1;
      end
      OP_MUL_BASE, OP_MUL_PAIR: begin
        prod_q <= {{(PROD_W-VAL_W){1'b0}}, mul_a} * PROD_W'(MS_PER_S);
      end
      OP_ACC_PAIR: begin
        sum_q <= sum_q + div_quo;
        cnt_q <= cnt_q + 1'b1;
      end
      OP_TAKE_RATE: begin
        rate_q <= (div_quo > {{PADW{1'b0}}, RATE_MAX}) ? RATE_MAX : div_quo[RATE_W-1:0];
      end
      default: ;
    endcase
  end

  // Result register; a waiting result does not block new work.
  assign held_ext = {6'b0, held_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_RESULT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESULT) begin
      out_q.status       <= cmd_i.status;
      out_q.eta_secs     <= cmd_i.with_eta ? div_quo[ETA_W-1:0] : '0;
      out_q.rate_q16     <= cmd_i.with_rate ? rate_q : '0;
      out_q.sample_count <= held_ext[CNT_OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Status toward the controller.
  assign held32 = {{(32-CW){1'b0}}, held_q};
  assign age    = item_q.time_ms - rd_stamp_q;

  always_comb begin
    sts_o.func         = func_e'(item_q.func);
    sts_o.frozen       = frozen_q;
    sts_o.prog_ge_goal = item_q.progress >= item_q.goal;
    sts_o.held_lt2     = held32 < 32'd2;
    sts_o.not_stable   = (span_q < min_q) || (held32 < 32'(STABLE_MIN_CNT));
    sts_o.base_zero    = (span_q == '0) || (last_val_q < first_val_q);
    sts_o.age_stale    = (age > AGE_LIMIT_MS) && (held_q != '0);
    sts_o.pair_ok      = pair_ok_q;
    sts_o.more_pairs   = off_q < held_q;
    sts_o.cnt_zero     = cnt_q == '0;
    sts_o.rate_zero    = rate_q == '0;
    sts_o.div_busy     = div_busy;
    sts_o.eta_over     = (div_quo > NW'(ETA_LIMIT)) ||
                         ((div_quo == NW'(ETA_LIMIT)) && (div_rem != '0));
    sts_o.out_free     = !out_valid_q || !out_stall_i;
  end

  // The window never holds more than its depth.
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(WINDOW_DEPTH))
    else $error("window count above depth");

  // The oldest pointer stays inside the ring.
  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q <= AW'(WINDOW_DEPTH - 1))
    else $error("oldest pointer outside ring");

  // A division is never started while one is running.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // A new result is never loaded over one still being stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_RESULT) |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

### design/wreta_ctrl.sv
// Controller state machine: sequences record, query, clear and no-op
// requests as commands to wreta_dp. Uses wreta_pkg.
module wreta_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  wreta_pkg::sts_t sts_i,
  output wreta_pkg::cmd_t cmd_o
);
  import wreta_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_REC_ROOM,
    S_REC_WR,
    S_REC_RD,
    S_REC_AGE,
    S_Q_START,
    S_Q_FIRST,
    S_Q_RDLAST,
    S_Q_LAST,
    S_Q_CHK,
    S_P_RD,
    S_P_CAP,
    S_P_CHK,
    S_P_DIV,
    S_P_WAIT,
    S_P_NEXT,
    S_B_MUL,
    S_B_DIV,
    S_AVG_DIV,
    S_R_WAIT,
    S_R_CHK,
    S_E_DIV,
    S_E_WAIT,
    S_RESULT
  } state_e;

  state_e  state_q;
  status_e res_status_q;
  logic    res_eta_q;
  logic    res_rate_q;

  // Requests are taken only between items.
  assign in_stall_o = (state_q != S_IDLE);

  // Command for the datapath in each state.
  always_comb begin
    cmd_o.op        = OP_IDLE;
    cmd_o.status    = res_status_q;
    cmd_o.with_eta  = res_eta_q;
    cmd_o.with_rate = res_rate_q;
    unique case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? OP_LATCH : OP_IDLE;
      S_DISPATCH: cmd_o.op = (sts_i.func == FUNC_CLEAR) ? OP_CLEAR : OP_IDLE;
      S_REC_ROOM: cmd_o.op = OP_MAKE_ROOM;
      S_REC_WR:   cmd_o.op = OP_WRITE;
      S_REC_RD:   cmd_o.op = OP_RD_FIRST;
      S_REC_AGE:  cmd_o.op = sts_i.age_stale ? OP_DROP : OP_IDLE;
      S_Q_START: begin
        if (!sts_i.frozen && !sts_i.prog_ge_goal && !sts_i.held_lt2) begin
          cmd_o.op = OP_RD_FIRST;
        end
      end
      S_Q_FIRST:  cmd_o.op = OP_CAP_FIRST;
      S_Q_RDLAST: cmd_o.op = OP_RD_LAST;
      S_Q_LAST:   cmd_o.op = OP_CAP_LAST;
      S_Q_CHK:    cmd_o.op = OP_IDLE;
      S_P_RD:     cmd_o.op = OP_RD_NEXT;
      S_P_CAP:    cmd_o.op = OP_CAP_PAIR;
      S_P_CHK:    cmd_o.op = sts_i.pair_ok ? OP_MUL_PAIR : OP_IDLE;
      S_P_DIV:    cmd_o.op = OP_DIV_PAIR;
      S_P_WAIT:   cmd_o.op = sts_i.div_busy ? OP_IDLE : OP_ACC_PAIR;
      S_P_NEXT:   cmd_o.op = OP_IDLE;
      S_B_MUL:    cmd_o.op = OP_MUL_BASE;
      S_B_DIV:    cmd_o.op = OP_DIV_BASE;
      S_AVG_DIV:  cmd_o.op = OP_DIV_AVG;
      S_R_WAIT:   cmd_o.op = sts_i.div_busy ? OP_IDLE : OP_TAKE_RATE;
      S_R_CHK:    cmd_o.op = sts_i.rate_zero ? OP_IDLE : OP_DIV_ETA;
      S_E_DIV:    cmd_o.op = OP_IDLE;
      S_E_WAIT:   cmd_o.op = OP_IDLE;
      S_RESULT:   cmd_o.op = sts_i.out_free ? OP_RESULT : OP_IDLE;
    endcase
  end

  // State register and the pending result code.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_status_q <= ST_DONE;
      res_eta_q    <= 1'b0;
      res_rate_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_status_q <= ST_DONE;
          res_eta_q    <= 1'b0;
          res_rate_q   <= 1'b0;
          unique case (sts_i.func)
            FUNC_RECORD: state_q <= S_REC_ROOM;
            FUNC_QUERY:  state_q <= S_Q_START;
            FUNC_CLEAR:  state_q <= S_RESULT;
            FUNC_NOP:    state_q <= S_RESULT;
          endcase
        end
        S_REC_ROOM: state_q <= S_REC_WR;
        S_REC_WR:   state_q <= S_REC_RD;
        S_REC_RD:   state_q <= S_REC_AGE;
        S_REC_AGE:  state_q <= sts_i.age_stale ? S_REC_RD : S_RESULT;
        S_Q_START: begin
          priority if (sts_i.frozen) begin
            res_status_q <= ST_FROZEN;
            state_q      <= S_RESULT;
          end else if (sts_i.prog_ge_goal) begin
            res_status_q <= ST_ESTIMATE;
            state_q      <= S_RESULT;
          end else if (sts_i.held_lt2) begin
            res_status_q <= ST_NOT_STABLE;
            state_q      <= S_RESULT;
          end else begin
            state_q <= S_Q_FIRST;
          end
        end
        S_Q_FIRST:  state_q <= S_Q_RDLAST;
        S_Q_RDLAST: state_q <= S_Q_LAST;
        S_Q_LAST:   state_q <= S_Q_CHK;
        S_Q_CHK: begin
          priority if (sts_i.not_stable) begin
            res_status_q <= ST_NOT_STABLE;
            state_q      <= S_RESULT;
          end else if (sts_i.base_zero) begin
            res_status_q <= ST_STALLED;
            state_q      <= S_RESULT;
          end else begin
            state_q <= S_P_RD;
          end
        end
        S_P_RD:  state_q <= S_P_CAP;
        S_P_CAP: state_q <= S_P_CHK;
        S_P_CHK: state_q <= sts_i.pair_ok ? S_P_DIV : S_P_NEXT;
        S_P_DIV: state_q <= S_P_WAIT;
        S_P_WAIT: begin
          if (!sts_i.div_busy) begin
            state_q <= S_P_NEXT;
          end
        end
        S_P_NEXT: begin
          priority if (sts_i.more_pairs) begin
            state_q <= S_P_RD;
          end else if (sts_i.cnt_zero) begin
            state_q <= S_B_MUL;
          end else begin
            state_q <= S_AVG_DIV;
          end
        end
        S_B_MUL:   state_q <= S_B_DIV;
        S_B_DIV:   state_q <= S_R_WAIT;
        S_AVG_DIV: state_q <= S_R_WAIT;
        S_R_WAIT: begin
          if (!sts_i.div_busy) begin
            state_q <= S_R_CHK;
          end
        end
        S_R_CHK: begin
          if (sts_i.rate_zero) begin
            res_status_q <= ST_STALLED;
            state_q      <= S_RESULT;
          end else begin
            state_q <= S_E_DIV;
          end
        end
        S_E_DIV: state_q <= S_E_WAIT;
        S_E_WAIT: begin
          if (!sts_i.div_busy) begin
            res_rate_q <= 1'b1;
            state_q    <= S_RESULT;
            if (sts_i.eta_over) begin
              res_status_q <= ST_TOO_FAR;
            end else begin
              res_status_q <= ST_ESTIMATE;
              res_eta_q    <= 1'b1;
            end
          end
        end
        S_RESULT: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

### design/windowed_rate_eta_estimator.sv
// Windowed progress-rate and time-remaining estimator, top level.
// Joins wreta_ctrl and wreta_dp; uses wreta_pkg.
//
// Requests arrive on in_valid_i/in_stall_o carrying func, time_ms, progress
// and goal; a request is taken when valid is high and stall is low. Every
// request yields exactly one result on out_valid_o/out_stall_i.
// Record appends a sample and ages out old ones. A query may end early;
// a full query walks every adjacent sample pair and sends each qualifying
// pair through the single shared restoring divider (one quotient bit per
// cycle).
// One request is worked at a time; in_stall_o is high while it runs.
// The result sits in an output register, so a stalled receiver holds it
// while the next request is already being worked on.
// Configuration writes (minimum window span at index 0, frozen at index 1)
// are always ready; the user must make them only while the block is idle, as the block does not enforce this.
// Reset empties the window and loads a minimum span of 30000 ms, frozen 0.
module windowed_rate_eta_estimator #(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wreta_pkg::in_item_t             in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wreta_pkg::out_item_t            out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wreta_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wreta_pkg::TIME_W-1:0]    cfg_data_i
);
  import wreta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wreta_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  wreta_dp #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_item_i  (in_item_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

endmodule

### bench/windowed_rate_eta_estimator_test.sv
// Self-checking testbench for windowed_rate_eta_estimator.
// Drives directed and random record/query/clear/nop requests through a local
// rate predictor. Depends on wreta_pkg and the DUT only.
`timescale 1ns / 100ps

module windowed_rate_eta_estimator_test;
  import wreta_pkg::*;

  localparam int unsigned DEPTH = 32;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TIME_W-1:0] cfg_data_i = '0;

  windowed_rate_eta_estimator #(.WINDOW_DEPTH(DEPTH)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Predictor state: sample window and a copy of the registers.
  logic [TIME_W-1:0] win_stamp [DEPTH];
  logic [VAL_W-1:0] win_value [DEPTH];
  int unsigned win_oldest;
  int unsigned win_held;
  logic [TIME_W-1:0] min_span_ms;
  logic is_frozen;

  out_item_t pending_results[$];
  int unsigned mismatches;
  int unsigned status_seen [8];
  int unsigned burst_left;

  // Session state for well-formed random sample streams.
  logic [TIME_W-1:0] sess_time;
  logic [VAL_W-1:0] sess_value;

  typedef struct {
    in_item_t req;
    bit known;
    out_item_t res;
  } vector_t;
  vector_t directed_rows[$];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] pair_rate(logic [VAL_W-1:0] dv, logic [TIME_W-1:0] dt);
    return ({32'd0, dv} * 64'd65536000) / {16'd0, dt};
  endfunction

  // Rate over the held window: average of the qualifying pair rates, or
  // the first-to-last rate when no pair qualifies.
  function automatic logic [RATE_W-1:0] window_rate();
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] dt;
    logic [71:0] total;
    logic [71:0] avg;
    int unsigned npairs;
    int unsigned a;
    int unsigned b;
    int unsigned first;
    int unsigned last;
    first = win_oldest;
    last = (win_oldest + win_held - 1) % DEPTH;
    span = win_stamp[last] - win_stamp[first];
    if (span == 0 || win_value[last] < win_value[first]) return '0;
    avg = {8'd0, pair_rate(win_value[last] - win_value[first], span)};
    total = '0;
    npairs = 0;
    for (int k = 1; k < win_held; k++) begin
      a = (win_oldest + k - 1) % DEPTH;
      b = (win_oldest + k) % DEPTH;
      dt = win_stamp[b] - win_stamp[a];
      if (dt != 0 && win_value[b] >= win_value[a]) begin
        total += {8'd0, pair_rate(win_value[b] - win_value[a], dt)};
        npairs++;
      end
    end
    if (npairs > 0) avg = total / npairs;
    if (avg > {14'd0, RATE_MAX}) avg = {14'd0, RATE_MAX};
    return avg[RATE_W-1:0];
  endfunction

  // Advances the predictor by one request and returns its result.
  function automatic out_item_t predict_result(in_item_t req);
    out_item_t res;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] span;
    logic [RATE_W-1:0] rate;
    logic [63:0] scaled;
    logic [63:0] quo;
    logic [63:0] rmd;
    int unsigned slot;
    res = '0;
    res.status = ST_DONE;
    case (func_e'(req.func))
      FUNC_RECORD: begin
        if (win_held >= DEPTH) begin
          win_oldest = (win_oldest + 1) % DEPTH;
          win_held = DEPTH - 1;
        end
        slot = (win_oldest + win_held) % DEPTH;
        win_stamp[slot] = req.time_ms;
        win_value[slot] = req.progress;
        win_held++;
        age = req.time_ms - win_stamp[win_oldest];
        while (win_held > 0 && age > AGE_LIMIT_MS) begin
          win_oldest = (win_oldest + 1) % DEPTH;
          win_held--;
          age = req.time_ms - win_stamp[win_oldest];
        end
      end
      FUNC_QUERY: begin
        span = win_stamp[(win_oldest + win_held - 1) % DEPTH] - win_stamp[win_oldest];
        if (is_frozen) begin
          res.status = ST_FROZEN;
        end else if (req.progress >= req.goal) begin
          res.status = ST_ESTIMATE;
        end else if (win_held < 2 || span < min_span_ms || win_held < STABLE_MIN_CNT) begin
          res.status = ST_NOT_STABLE;
        end else begin
          rate = window_rate();
          if (rate == 0) begin
            res.status = ST_STALLED;
          end else begin
            scaled = {16'd0, req.goal - req.progress, 16'd0};
            quo = scaled / {6'd0, rate};
            rmd = scaled % {6'd0, rate};
            res.rate_q16 = rate;
            if (quo > ETA_LIMIT || (quo == ETA_LIMIT && rmd != 0)) begin
              res.status = ST_TOO_FAR;
            end else begin
              res.status = ST_ESTIMATE;
              res.eta_secs = quo[ETA_W-1:0];
            end
          end
        end
      end
      FUNC_CLEAR: begin
        win_held = 0;
        win_oldest = 0;
      end
      default: ;
    endcase
    res.sample_count = win_held[CNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
  endtask

  // Result side: random stall pattern and in-order comparison.
  int unsigned stall_mode;
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_item_o.status), 64'd0);
      end else begin
        if (out_item_o.status != pending_results[0].status)
          report_mismatch("status", 64'(out_item_o.status), 64'(pending_results[0].status));
        if (out_item_o.eta_secs != pending_results[0].eta_secs)
          report_mismatch("eta_secs", 64'(out_item_o.eta_secs),
                          64'(pending_results[0].eta_secs));
        if (out_item_o.rate_q16 != pending_results[0].rate_q16)
          report_mismatch("rate_q16", 64'(out_item_o.rate_q16),
                          64'(pending_results[0].rate_q16));
        if (out_item_o.sample_count != pending_results[0].sample_count)
          report_mismatch("sample_count", 64'(out_item_o.sample_count),
                          64'(pending_results[0].sample_count));
        status_seen[out_item_o.status]++;
        pending_results.delete(0);
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Presents one request, waits for it to be taken, then maybe idles.
  task automatic send_request(in_item_t req, bit known, out_item_t res);
    out_item_t predicted;
    in_valid_i <= 1'b1;
    in_item_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_result(req);
    pending_results.insert(pending_results.size(), known ? res : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Holds the request side until every result is back and the block is idle.
  task automatic drain();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [TIME_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_MIN_WINDOW) min_span_ms = data;
    else is_frozen = data[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic add_row(func_e f, logic [TIME_W-1:0] t, logic [VAL_W-1:0] p,
                         logic [VAL_W-1:0] g, bit known, status_e st, int unsigned cnt);
    vector_t row;
    row.req = '{func: f, time_ms: t, progress: p, goal: g};
    row.known = known;
    row.res = '0;
    row.res.status = st;
    row.res.sample_count = cnt[CNT_OUT_W-1:0];
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Random request: mostly a well-formed sample stream, some noise.
  function automatic in_item_t random_request();
    in_item_t req;
    int unsigned pick;
    req = '0;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      req.func = FUNC_CLEAR;
      sess_time = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom}) - 48'd40000
                                               : 48'($urandom_range(0, 100000));
      sess_value = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    end else if (pick < 8) begin
      req = '{func: func_e'($urandom_range(0, 3)), time_ms: 48'({$urandom, $urandom}),
              progress: $urandom, goal: $urandom};
    end else if (pick < 70) begin
      req.func = FUNC_RECORD;
      sess_time += ($urandom_range(0, 15) == 0) ? 48'd0 : 48'($urandom_range(500, 9000));
      if ($urandom_range(0, 20) == 0) sess_time += 48'($urandom_range(100000, 200000));
      if ($urandom_range(0, 12) == 0) sess_value -= $urandom_range(1, 500);
      else if ($urandom_range(0, 6) != 0) sess_value += $urandom_range(0, 6000);
      req.time_ms = sess_time;
      req.progress = sess_value;
    end else begin
      req.func = FUNC_QUERY;
      req.progress = sess_value - (($urandom_range(0, 5) == 0) ? $urandom_range(0, 2000) : 0);
      case ($urandom_range(0, 3))
        0: req.goal = $urandom;
        1: req.goal = req.progress;
        default: req.goal = req.progress + $urandom_range(1, 80000000);
      endcase
    end
    return req;
  endfunction

  typedef struct {
    logic [TIME_W-1:0] span;
    logic frz;
  } setting_t;

  initial begin
    setting_t settings [6];
    out_item_t none;
    int unsigned nitems;
    none = '0;
    min_span_ms = MIN_WINDOW_RST;
    is_frozen = 1'b0;
    win_oldest = 0;
    win_held = 0;
    mismatches = 0;
    burst_left = 0;
    stall_left = 0;
    nitems = 0;
    sess_time = '0;
    sess_value = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part on reset settings: empty window, extremes, ageing,
    // timestamp wrap, unused selector, then a short steady stream.
    add_row(FUNC_QUERY, '0, 0, 1, 1, ST_NOT_STABLE, 0);
    add_row(FUNC_RECORD, '0, 0, 0, 1, ST_DONE, 1);
    add_row(FUNC_QUERY, '1, '1, '1, 1, ST_ESTIMATE, 1);
    add_row(FUNC_NOP, '1, '1, '1, 1, ST_DONE, 1);
    add_row(FUNC_CLEAR, '1, '1, '1, 1, ST_DONE, 0);
    add_row(FUNC_RECORD, '1, '1, 0, 1, ST_DONE, 1);
    add_row(FUNC_RECORD, 48'd5, 32'd7, 0, 1, ST_DONE, 2);
    add_row(FUNC_RECORD, 48'd200000, 32'd9, 0, 1, ST_DONE, 1);
    add_row(FUNC_CLEAR, '0, 0, 0, 1, ST_DONE, 0);
    for (int k = 0; k < 12; k++)
      add_row(FUNC_RECORD, 48'(10000 + 5000 * k), 32'(100 * k), 0, 0, ST_DONE, 0);
    add_row(FUNC_QUERY, '0, 32'd1100, 32'd1300, 0, ST_DONE, 0);
    add_row(FUNC_QUERY, '0, 32'd1100, '1, 0, ST_DONE, 0);
    add_row(FUNC_QUERY, '0, 32'd1300, 32'd1200, 1, ST_ESTIMATE, 12);
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].res);
    drain();

    // Random phases, each under its own register setting.
    settings[0] = '{span: 48'd0, frz: 1'b0};
    settings[1] = '{span: 48'd20000, frz: 1'b0};
    settings[2] = '{span: '1, frz: 1'b0};
    settings[3] = '{span: 48'd30000, frz: 1'b1};
    settings[4] = '{span: 48'd45000, frz: 1'b0};
    settings[5] = '{span: 48'd30000, frz: 1'b0};
    foreach (settings[p]) begin
      write_register(CFG_MIN_WINDOW, settings[p].span);
      write_register(CFG_FROZEN, {47'd0, settings[p].frz});
      repeat (p == 2 || p == 3 ? 25 : 45) begin
        send_request(random_request(), 1'b0, none);
        nitems++;
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Ran %0d directed and %0d random requests over 6 register settings.",
             directed_rows.size(), nitems);
    $display("Results by status: est %0d, frozen %0d, unstable %0d, stalled %0d, far %0d, done %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #60000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
